// ===== rtl/uwrf_pkg.sv =====
`timescale 1ns / 1ps

package uwrf_pkg;

    // Default ring size; the ring holds one entry less than its size.
    localparam int FIFO_DEPTH_DEF = 64;

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int EXTRA_W = 4;
    localparam int COUNT_W = 6;
    localparam int CIDX_W  = 3;

    // Stream widths: tdata fields packed from bit 0 and padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // Host command codes.
    localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TAKE  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FLUSH = 3'd5;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_RX_CENTER = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RX_BIT    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RX_STOP   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TX_BIT    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TX_EXTRA  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_INVERT    = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_RX_EN     = 3'd6;

    // Register reset values.
    localparam logic [EXTRA_W-1:0] TX_EXTRA_RST = 4'd5;
    localparam logic               INVERT_RST   = 1'b1;

    // Frame phase codes shared by receiver and transmitter.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_A    = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_C    = 2'd3;

    // Receiver timing and polarity.
    typedef struct packed {
        logic [TICK_W-1:0] center_ticks;
        logic [TICK_W-1:0] bit_ticks;
        logic [TICK_W-1:0] stop_ticks;
        logic              invert;
    } t_rx_cfg;

    // Completed byte from the receiver.
    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] data;
    } t_rx_push;

endpackage

// ===== rtl/uwrf_ram.sv =====
`timescale 1ns / 1ps

module uwrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/uwrf_rx.sv =====
`timescale 1ns / 1ps

module uwrf_rx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_line,
    input  uwrf_pkg::t_rx_cfg i_cfg,
    output uwrf_pkg::t_rx_push o_push
);

    import uwrf_pkg::*;

    logic [1:0]        r_phase, n_phase;
    logic [TICK_W-1:0] r_timer, n_timer;
    logic [3:0]        r_idx, n_idx;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic              r_prev, n_prev;
    logic              push;

    // Frame sequencer, advanced once per tick.
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_prev  = r_prev;
        push    = 1'b0;
        if (i_tick) begin
            n_prev = i_line;
            if (r_phase == PH_IDLE) begin
                // Arm on a transition to the start level.
                if (i_cfg.stop_ticks != '0 && i_line != r_prev && i_line == i_cfg.invert) begin
                    n_phase = PH_A;
                    n_timer = i_cfg.center_ticks;
                end
            end else if (r_timer != '0) begin
                n_timer = r_timer - 1'b1;
            end else begin
                case (r_phase)
                    PH_A: begin
                        n_phase = PH_DATA;
                        n_idx   = '0;
                        n_shift = '0;
                        n_timer = i_cfg.bit_ticks;
                    end
                    PH_DATA: begin
                        n_shift = r_shift | (BYTE_W'(i_line) << r_idx[2:0]);
                        n_idx   = r_idx + 1'b1;
                        if (r_idx >= 4'd7) begin
                            n_phase = PH_C;
                            n_timer = i_cfg.stop_ticks;
                        end else begin
                            n_timer = i_cfg.bit_ticks;
                        end
                    end
                    default: begin
                        // End of the stop wait: hand the byte to the ring.
                        push    = 1'b1;
                        n_phase = PH_IDLE;
                        n_idx   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_idx   <= '0;
            r_shift <= '0;
            r_prev  <= !INVERT_RST;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_prev  <= n_prev;
        end
    end

    assign o_push.push = push;
    assign o_push.data = r_shift ^ {BYTE_W{i_cfg.invert}};

endmodule

// ===== rtl/uart_with_rx_fifo_core.sv =====
`timescale 1ns / 1ps

// 8N1 UART core with a receive ring buffer, driven by host transactions.
// The slave stream carries one command per transaction: tuser is the command
// (tick, read, peek, write, take overflow, flush), tdata holds the sampled
// receive pin and the byte to send. Each command returns exactly one
// transaction on the master stream with the transmit pin level, the head
// byte for read or peek and its valid flag in tuser, the byte count, the
// sticky overflow flag and the transmitter busy flag.
// A command's result is registered when it is accepted and presented until
// taken. One command is accepted every cycle while results are taken; the
// ring's registered read port is prefetched at the next head address, so
// read and peek need no wait on the ring. s_axis_tready is high when the
// result register is empty or being taken; a stalled master side holds the
// result and stops new commands. Configuration writes are taken every
// cycle; the user must make them while idle, as the block does not enforce
// it. Synchronous active-low reset clears the pointers, flags and sequencers
// and loads the register defaults (start extension 5, inverted line,
// receiver off); ring contents are not cleared and need no clearing pass.

module uart_with_rx_fifo_core #(
    parameter int FIFO_DEPTH = uwrf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave stream. tdata: rx_line [0], tx_byte [8:1], zero [15:9].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [uwrf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: func [2:0].
    input  logic [uwrf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Master stream. tdata: tx_line [0], rx_data [8:1], available_count
    // [14:9], overflow_flag [15], tx_busy [16], zero [23:17].
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [uwrf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: rx_data_valid [0].
    output logic [uwrf_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [uwrf_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [uwrf_pkg::TICK_W-1:0]    i_cfg_data
);

    import uwrf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(FIFO_DEPTH);

    // Configuration registers.
    logic [TICK_W-1:0]  r_rx_center, r_rx_bit, r_rx_stop, r_tx_bit;
    logic [EXTRA_W-1:0] r_tx_extra;
    logic               r_invert, r_rx_en;

    // Ring buffer and transmitter state.
    logic [PW-1:0]      r_head, n_head, r_tail, n_tail;
    logic               r_ovf, n_ovf;
    logic [1:0]         r_tx_phase, n_tx_phase;
    logic [TICK_W:0]    r_tx_timer, n_tx_timer;
    logic [3:0]         r_tx_idx, n_tx_idx;
    logic [BYTE_W-1:0]  r_tx_shift, n_tx_shift;

    // Read bypass for a write to the prefetched address.
    logic               r_byp;
    logic [BYTE_W-1:0]  r_byp_data;

    // Result register.
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;

    logic              accept, cfg_we, tick, empty, full;
    logic [FUNC_W-1:0] func;
    logic              rx_line;
    logic [BYTE_W-1:0] tx_byte, ram_q, head_data, rd_data;
    logic              rd_valid, ovf_out, tx_line;
    logic [PW:0]       count;
    logic [PW-1:0]     tail_next, head_next;
    logic              ram_we;
    t_rx_cfg           rx_cfg;
    t_rx_push          rx_push;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid;

    assign func    = s_axis_tuser[FUNC_W-1:0];
    assign rx_line = s_axis_tdata[0];
    assign tx_byte = s_axis_tdata[BYTE_W:1];
    assign tick    = accept && func == FN_TICK;

    // Receiver.
    assign rx_cfg.center_ticks = r_rx_center;
    assign rx_cfg.bit_ticks    = r_rx_bit;
    assign rx_cfg.stop_ticks   = r_rx_stop;
    assign rx_cfg.invert       = r_invert;

    uwrf_rx u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_line  (rx_line),
        .i_cfg   (rx_cfg),
        .o_push  (rx_push)
    );

    // Ring pointers.
    assign tail_next = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
    assign head_next = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign empty     = r_head == r_tail;
    assign full      = tail_next == r_head;
    assign ram_we    = rx_push.push && !full;
    assign head_data = r_byp ? r_byp_data : ram_q;

    uwrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (rx_push.data),
        .i_raddr (n_head),
        .o_rdata (ram_q)
    );

    // Command decode and next state.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_ovf      = r_ovf;
        n_tx_phase = r_tx_phase;
        n_tx_timer = r_tx_timer;
        n_tx_idx   = r_tx_idx;
        n_tx_shift = r_tx_shift;
        rd_data    = '0;
        rd_valid   = 1'b0;
        if (rx_push.push) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_tail = tail_next;
            end
        end
        if (accept) begin
            case (func)
                FN_TICK: begin
                    if (r_tx_phase != PH_IDLE) begin
                        if (r_tx_timer != '0) begin
                            n_tx_timer = r_tx_timer - 1'b1;
                        end else begin
                            case (r_tx_phase)
                                PH_A: begin
                                    n_tx_phase = PH_DATA;
                                    n_tx_idx   = '0;
                                    n_tx_timer = {1'b0, r_tx_bit};
                                end
                                PH_DATA: begin
                                    n_tx_idx = r_tx_idx + 1'b1;
                                    if (r_tx_idx >= 4'd7) begin
                                        n_tx_phase = PH_C;
                                        n_tx_idx   = '0;
                                    end
                                    n_tx_timer = {1'b0, r_tx_bit};
                                end
                                default: begin
                                    n_tx_phase = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                FN_READ: begin
                    if (r_rx_en && !empty) begin
                        rd_data  = head_data;
                        rd_valid = 1'b1;
                        n_head   = head_next;
                    end
                end
                FN_PEEK: begin
                    if (!empty) begin
                        rd_data  = head_data;
                        rd_valid = 1'b1;
                    end
                end
                FN_WRITE: begin
                    if (r_tx_bit != '0 && r_tx_phase == PH_IDLE) begin
                        n_tx_phase = PH_A;
                        n_tx_shift = tx_byte;
                        n_tx_idx   = '0;
                        n_tx_timer = {1'b0, r_tx_bit} + (TICK_W + 1)'(r_tx_extra);
                    end
                end
                FN_FLUSH: begin
                    n_head = '0;
                    n_tail = '0;
                end
                default: begin
                end
            endcase
        end
        ovf_out = n_ovf;
        if (accept && func == FN_TAKE) begin
            n_ovf = 1'b0;
        end
        // Enabling the receiver empties the ring and clears overflow.
        if (cfg_we && i_cfg_index == CFG_RX_EN && i_cfg_data[0]) begin
            n_head = '0;
            n_tail = '0;
            n_ovf  = 1'b0;
        end
    end

    // Result fields, taken from the state after the command.
    always_comb begin
        case (n_tx_phase)
            PH_A:    tx_line = r_invert;
            PH_DATA: tx_line = n_tx_shift[n_tx_idx[2:0]] ^ r_invert;
            default: tx_line = !r_invert;
        endcase
        count = {1'b0, n_tail} - {1'b0, n_head} + ((n_tail < n_head) ? DEPTH_W : '0);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_center <= '0;
            r_rx_bit    <= '0;
            r_rx_stop   <= '0;
            r_tx_bit    <= '0;
            r_tx_extra  <= TX_EXTRA_RST;
            r_invert    <= INVERT_RST;
            r_rx_en     <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_RX_CENTER: r_rx_center <= i_cfg_data;
                CFG_RX_BIT:    r_rx_bit    <= i_cfg_data;
                CFG_RX_STOP:   r_rx_stop   <= i_cfg_data;
                CFG_TX_BIT:    r_tx_bit    <= i_cfg_data;
                CFG_TX_EXTRA:  r_tx_extra  <= i_cfg_data[EXTRA_W-1:0];
                CFG_INVERT:    r_invert    <= i_cfg_data[0];
                CFG_RX_EN:     r_rx_en     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Ring, transmitter and bypass state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_ovf      <= 1'b0;
            r_tx_phase <= PH_IDLE;
            r_tx_timer <= '0;
            r_tx_idx   <= '0;
            r_tx_shift <= '0;
            r_byp      <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_ovf      <= n_ovf;
            r_tx_phase <= n_tx_phase;
            r_tx_timer <= n_tx_timer;
            r_tx_idx   <= n_tx_idx;
            r_tx_shift <= n_tx_shift;
            r_byp      <= ram_we && r_tail == n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= rx_push.data;
    end

    // Result register: loaded on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_tdata <= {7'd0, n_tx_phase != PH_IDLE, ovf_out,
                          r_rx_en ? COUNT_W'(count) : COUNT_W'(0), rd_data, tx_line};
            r_m_tuser <= rd_valid;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

`ifndef ASSERT_OFF
    // Pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= PTR_LAST && r_tail <= PTR_LAST)
        else $error("ring pointer out of range");

    // A byte arriving at a full ring raises the overflow flag.
    a_ovf_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_push.push && full && !cfg_we |=> r_ovf)
        else $error("overflow not flagged");

    // A successful read moves the head.
    a_read_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && func == FN_READ && r_rx_en && !empty && !cfg_we |=> r_head != $past(r_head))
        else $error("read did not advance head");

    // An accepted write on an idle, enabled transmitter starts a frame.
    a_tx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && func == FN_WRITE && r_tx_phase == PH_IDLE && r_tx_bit != '0
        |=> r_tx_phase == PH_A)
        else $error("write did not start a frame");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import uwrf_pkg::*;

    // A small ring so that overflow is reached within a short run.
    localparam int RING_SIZE = 8;
    localparam int RIDX_W = $clog2(RING_SIZE);
    localparam int LONG_HOLD = 80;

    // Command codes the block treats as no operation.
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    // One host command as it travels on the slave stream.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              line;
        logic [BYTE_W-1:0] txb;
    } t_host_cmd;

    // One status word as it comes back on the master stream.
    typedef struct packed {
        logic               tx_line;
        logic [BYTE_W-1:0]  rx_byte;
        logic               byte_ok;
        logic [COUNT_W-1:0] count;
        logic               ovf;
        logic               busy;
    } t_uart_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index = '0;
    logic [TICK_W-1:0]    i_cfg_data = '0;

    uart_with_rx_fifo_core #(.FIFO_DEPTH(RING_SIZE)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Commands waiting to be sent and status words waiting to be seen.
    t_host_cmd    pending_cmds[$];
    t_uart_status results_due[$];
    t_host_cmd    next_cmd;

    // Transaction flags from the last rising edge, used by the falling-edge drivers.
    logic cmd_fire = 1'b0;
    logic res_fire = 1'b0;
    logic cfg_fire = 1'b0;

    int  cmds_issued = 0;
    int  cmds_taken = 0;
    int  errors = 0;
    int  frames_queued = 0;
    int  bytes_returned = 0;
    int  ovf_reports = 0;
    int  long_holds = 0;
    int  send_gap = 0;
    int  take_gap = 0;
    bit  sender_gaps_on = 1'b1;
    bit  receiver_gaps_on = 1'b1;
    bit  long_hold_req = 1'b0;

    // Stimulus shaping: line timing as last programmed, and command mix.
    int  gen_center, gen_bit, gen_stop, gen_span;
    bit  gen_inv;
    int  read_pct = 20;
    int  flush_pct = 3;
    int  mix_pct = 20;

    // Predicted UART state.
    logic [BYTE_W-1:0]  ring [RING_SIZE];
    int                 rd_ptr, wr_ptr;
    logic               ovf_sticky, rx_prev;
    logic [1:0]         rx_ph, tx_ph;
    int                 rx_left, tx_left, rx_nbit, tx_nbit;
    logic [BYTE_W-1:0]  rx_acc, tx_data;

    // Predicted register contents.
    logic [TICK_W-1:0]  cf_center, cf_bit, cf_stop, cf_txbit;
    logic [EXTRA_W-1:0] cf_extra;
    logic               cf_inv, cf_rxen;

    // Clock generation.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic void uart_reset_state();
        cf_center = '0;
        cf_bit = '0;
        cf_stop = '0;
        cf_txbit = '0;
        cf_extra = TX_EXTRA_RST;
        cf_inv = INVERT_RST;
        cf_rxen = 1'b0;
        rd_ptr = 0;
        wr_ptr = 0;
        ovf_sticky = 1'b0;
        rx_prev = ~cf_inv;
        rx_ph = PH_IDLE;
        rx_left = 0;
        rx_nbit = 0;
        rx_acc = '0;
        tx_ph = PH_IDLE;
        tx_left = 0;
        tx_nbit = 0;
        tx_data = '0;
    endfunction

    function automatic void uart_write_reg(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] val);
        case (idx)
            CFG_RX_CENTER: cf_center = val;
            CFG_RX_BIT:    cf_bit = val;
            CFG_RX_STOP:   cf_stop = val;
            CFG_TX_BIT:    cf_txbit = val;
            CFG_TX_EXTRA:  cf_extra = val[EXTRA_W-1:0];
            CFG_INVERT:    cf_inv = val[0];
            CFG_RX_EN: begin
                // Turning the receiver on also empties the ring and clears overflow.
                cf_rxen = val[0];
                if (val[0]) begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                    ovf_sticky = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // Applies one host command to the predicted state and returns the status word.
    function automatic t_uart_status uart_apply_cmd(logic [FUNC_W-1:0] fn, logic line,
                                                    logic [BYTE_W-1:0] txb);
        t_uart_status st;
        logic         ovf_before;
        st = '0;
        case (fn)
            FN_TICK: begin
                // Receiver: arm on an edge to the start level, then count and sample.
                if (rx_ph == PH_IDLE) begin
                    if (cf_stop != '0 && line != rx_prev && line == cf_inv) begin
                        rx_ph = PH_A;
                        rx_left = int'(cf_center);
                    end
                end else if (rx_left != 0) begin
                    rx_left--;
                end else if (rx_ph == PH_A) begin
                    rx_ph = PH_DATA;
                    rx_nbit = 0;
                    rx_acc = '0;
                    rx_left = int'(cf_bit);
                end else if (rx_ph == PH_DATA) begin
                    rx_acc = rx_acc | (8'(line) << rx_nbit);
                    rx_nbit++;
                    if (rx_nbit >= 8) begin
                        rx_ph = PH_C;
                        rx_left = int'(cf_stop);
                    end else begin
                        rx_left = int'(cf_bit);
                    end
                end else begin
                    // End of stop time: push the byte, or flag overflow when full.
                    if ((wr_ptr + 1) % RING_SIZE != rd_ptr) begin
                        ring[RIDX_W'(wr_ptr)] = cf_inv ? ~rx_acc : rx_acc;
                        wr_ptr = (wr_ptr + 1) % RING_SIZE;
                    end else begin
                        ovf_sticky = 1'b1;
                    end
                    rx_ph = PH_IDLE;
                    rx_nbit = 0;
                end
                rx_prev = line;

                // Transmitter sequencing.
                if (tx_ph != PH_IDLE) begin
                    if (tx_left != 0) begin
                        tx_left--;
                    end else if (tx_ph == PH_A) begin
                        tx_ph = PH_DATA;
                        tx_nbit = 0;
                        tx_left = int'(cf_txbit);
                    end else if (tx_ph == PH_DATA) begin
                        tx_nbit++;
                        if (tx_nbit >= 8) begin
                            tx_ph = PH_C;
                            tx_nbit = 0;
                        end
                        tx_left = int'(cf_txbit);
                    end else begin
                        tx_ph = PH_IDLE;
                    end
                end
            end
            FN_READ: begin
                if (cf_rxen && rd_ptr != wr_ptr) begin
                    st.rx_byte = ring[RIDX_W'(rd_ptr)];
                    st.byte_ok = 1'b1;
                    rd_ptr = (rd_ptr + 1) % RING_SIZE;
                end
            end
            FN_PEEK: begin
                if (rd_ptr != wr_ptr) begin
                    st.rx_byte = ring[RIDX_W'(rd_ptr)];
                    st.byte_ok = 1'b1;
                end
            end
            FN_WRITE: begin
                if (cf_txbit != '0 && tx_ph == PH_IDLE) begin
                    tx_ph = PH_A;
                    tx_data = txb;
                    tx_nbit = 0;
                    tx_left = int'(cf_txbit) + int'(cf_extra);
                end
            end
            FN_FLUSH: begin
                rd_ptr = 0;
                wr_ptr = 0;
            end
            default: ;
        endcase

        ovf_before = ovf_sticky;
        if (fn == FN_TAKE) ovf_sticky = 1'b0;

        case (tx_ph)
            PH_A:    st.tx_line = cf_inv;
            PH_DATA: st.tx_line = tx_data[3'(tx_nbit)] ^ cf_inv;
            default: st.tx_line = ~cf_inv;
        endcase
        st.count = cf_rxen ? 6'((wr_ptr + RING_SIZE - rd_ptr) % RING_SIZE) : 6'd0;
        st.ovf = ovf_before;
        st.busy = (tx_ph != PH_IDLE);
        return st;
    endfunction

    function automatic int draw_gap(bit enabled);
        if (!enabled || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic rand_line();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic compare_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    // Command driver: holds each command until its transaction, then draws a gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || cmd_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                s_axis_tdata <= {7'b0, next_cmd.txb, next_cmd.line};
                s_axis_tuser <= next_cmd.func;
                s_axis_tvalid <= 1'b1;
                send_gap = draw_gap(sender_gaps_on);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Status receiver: random stalls per word, plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (res_fire) take_gap = draw_gap(receiver_gaps_on);
            if (long_hold_req) begin
                take_gap = LONG_HOLD;
                long_hold_req = 1'b0;
                long_holds++;
            end
            if (take_gap > 0) begin
                take_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: checks status words, then feeds register writes and commands to the predictor.
    always @(posedge i_clk) begin
        t_uart_status want, got;
        if (!i_rst_n) begin
            cmd_fire <= 1'b0;
            res_fire <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            cmd_fire <= s_axis_tvalid && s_axis_tready;
            res_fire <= m_axis_tvalid && m_axis_tready;
            cfg_fire <= i_cfg_valid && o_cfg_ready;

            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("status word with no command outstanding");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    got.tx_line = m_axis_tdata[0];
                    got.rx_byte = m_axis_tdata[8:1];
                    got.count = m_axis_tdata[14:9];
                    got.ovf = m_axis_tdata[15];
                    got.busy = m_axis_tdata[16];
                    got.byte_ok = m_axis_tuser[0];
                    compare_field("tx_line", 32'(want.tx_line), 32'(got.tx_line));
                    compare_field("rx_data", 32'(want.rx_byte), 32'(got.rx_byte));
                    compare_field("rx_data_valid", 32'(want.byte_ok), 32'(got.byte_ok));
                    compare_field("available_count", 32'(want.count), 32'(got.count));
                    compare_field("overflow_flag", 32'(want.ovf), 32'(got.ovf));
                    compare_field("tx_busy", 32'(want.busy), 32'(got.busy));
                    if (want.byte_ok) bytes_returned++;
                    if (want.ovf) ovf_reports++;
                end
            end

            if (i_cfg_valid && o_cfg_ready) uart_write_reg(i_cfg_index, i_cfg_data);

            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(uart_apply_cmd(s_axis_tuser, s_axis_tdata[0],
                                                     s_axis_tdata[8:1]));
                cmds_taken++;
            end
        end
    end

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    // Programs every register and records the line timing for frame generation.
    task automatic apply_setup(int center, int bit_ticks, int stop, int txbit, int extra,
                               bit inv, bit rxen);
        write_reg(CFG_RX_CENTER, TICK_W'(center));
        write_reg(CFG_RX_BIT, TICK_W'(bit_ticks));
        write_reg(CFG_RX_STOP, TICK_W'(stop));
        write_reg(CFG_TX_BIT, TICK_W'(txbit));
        write_reg(CFG_TX_EXTRA, TICK_W'(extra));
        write_reg(CFG_INVERT, TICK_W'(inv));
        write_reg(CFG_RX_EN, TICK_W'(rxen));
        gen_center = center;
        gen_bit = bit_ticks;
        gen_stop = stop;
        gen_inv = inv;
        gen_span = center + 1 + 8 * (bit_ticks + 1) + stop + 2;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (cmds_taken != cmds_issued || results_due.size() != 0);
    endtask

    task automatic queue_cmd(logic [FUNC_W-1:0] fn, logic line, logic [BYTE_W-1:0] txb);
        t_host_cmd c;
        c.func = fn;
        c.line = line;
        c.txb = txb;
        pending_cmds.push_back(c);
        cmds_issued++;
    endtask

    // A host command other than a tick; unused fields carry random values.
    task automatic queue_host_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < read_pct)
            queue_cmd(FN_READ, rand_line(), rand_byte());
        else if (r < read_pct + flush_pct)
            queue_cmd(FN_FLUSH, rand_line(), rand_byte());
        else if (r < read_pct + flush_pct + 20)
            queue_cmd(FN_WRITE, rand_line(), rand_byte());
        else if (r < read_pct + flush_pct + 32)
            queue_cmd(FN_TAKE, rand_line(), rand_byte());
        else if (r < read_pct + flush_pct + 37)
            queue_cmd($urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7,
                      rand_line(), rand_byte());
        else
            queue_cmd(FN_PEEK, rand_line(), rand_byte());
    endtask

    // One serial frame as a run of ticks timed to the programmed receiver, with host
    // commands mixed in. A broken frame gets a flipped level and may also be cut short.
    task automatic queue_frame(logic [BYTE_W-1:0] data, bit broken);
        int  bad_pos, cut_pos, last_pos;
        logic lvl;
        last_pos = gen_span - 1;
        bad_pos = broken ? $urandom_range(1, last_pos) : -1;
        cut_pos = (broken && $urandom_range(0, 1)) ? $urandom_range(1, last_pos) : last_pos + 1;
        queue_cmd(FN_TICK, ~gen_inv, rand_byte());
        for (int p = 0; p <= last_pos; p++) begin
            if (p < gen_center + 2)
                lvl = gen_inv;
            else if (p <= gen_center + 1 + 8 * (gen_bit + 1))
                lvl = data[3'((p - gen_center - 2) / (gen_bit + 1))] ^ gen_inv;
            else
                lvl = ~gen_inv;
            if (p == bad_pos) lvl = ~lvl;
            if (p >= cut_pos) lvl = ~gen_inv;
            if (p > 0 && $urandom_range(0, 99) < mix_pct) queue_host_cmd();
            queue_cmd(FN_TICK, lvl, rand_byte());
        end
        repeat ($urandom_range(0, 2)) queue_cmd(FN_TICK, ~gen_inv, rand_byte());
        frames_queued++;
    endtask

    // Random line levels, then idle ticks to end any frame they began; only 20 for long spans.
    task automatic queue_noise();
        repeat ($urandom_range(1, 10)) queue_cmd(FN_TICK, rand_line(), rand_byte());
        repeat ((gen_span <= 150) ? gen_span + 2 : 20)
            queue_cmd(FN_TICK, ~gen_inv, rand_byte());
    endtask

    task automatic run_traffic(int n, int frame_pct, int noise_pct);
        int stop_at, r;
        stop_at = cmds_issued + n;
        while (cmds_issued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < frame_pct && gen_span <= 150)
                queue_frame(rand_byte(), $urandom_range(0, 9) == 0);
            else if (r < frame_pct + noise_pct)
                queue_noise();
            else
                queue_host_cmd();
        end
    endtask

    // Main sequence.
    initial begin
        uart_reset_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: receiver cannot arm, transmitter disabled, every command at least once.
        gen_inv = INVERT_RST;
        queue_cmd(FN_TICK, 1'b1, 8'h00);
        queue_cmd(FN_TICK, 1'b0, 8'hFF);
        queue_cmd(FN_READ, 1'b0, 8'h00);
        queue_cmd(FN_PEEK, 1'b1, 8'h00);
        queue_cmd(FN_WRITE, 1'b0, 8'h00);
        queue_cmd(FN_WRITE, 1'b1, 8'hFF);
        queue_cmd(FN_TAKE, 1'b0, 8'h00);
        queue_cmd(FN_FLUSH, 1'b0, 8'h00);
        queue_cmd(FN_SPARE6, 1'b1, 8'hFF);
        queue_cmd(FN_SPARE7, 1'b0, 8'h00);
        wait_drained();

        // Fastest timing: one clean frame, peek, reads past empty, write while busy.
        apply_setup(0, 0, 1, 1, 0, 1'b1, 1'b1);
        mix_pct = 0;
        queue_frame(8'hA5, 1'b0);
        queue_cmd(FN_PEEK, 1'b0, 8'h00);
        queue_cmd(FN_READ, 1'b0, 8'h00);
        queue_cmd(FN_READ, 1'b0, 8'h00);
        queue_cmd(FN_WRITE, 1'b0, 8'hFF);
        queue_cmd(FN_WRITE, 1'b0, 8'h00);
        queue_cmd(FN_TAKE, 1'b0, 8'h00);
        wait_drained();

        // Few reads so the ring fills and overflows; a long stall on the status side.
        read_pct = 8;
        flush_pct = 0;
        mix_pct = 20;
        run_traffic(130, 75, 5);
        @(posedge i_clk);
        long_hold_req = 1'b1;
        wait_drained();
        read_pct = 45;
        flush_pct = 3;
        run_traffic(50, 40, 5);
        wait_drained();

        // Normal polarity, slower bits, long start extension; re-enabling clears the ring.
        apply_setup(1, 2, 2, 2, 15, 1'b0, 1'b1);
        read_pct = 25;
        mix_pct = 25;
        run_traffic(110, 60, 10);
        @(posedge i_clk);
        long_hold_req = 1'b1;
        wait_drained();

        // Receiver not listening: frames still land, reads give nothing, count reads zero.
        apply_setup(1, 2, 2, 2, 15, 1'b0, 1'b0);
        run_traffic(60, 60, 5);
        wait_drained();

        // Inverted line again, no idling on either side.
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
        apply_setup(2, 1, 3, 3, 7, 1'b1, 1'b1);
        run_traffic(90, 60, 8);
        wait_drained();
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;

        // Full-scale timing: receiver and transmitter stay inside their waits.
        apply_setup(65535, 65535, 65535, 65535, 15, 1'b0, 1'b1);
        run_traffic(35, 0, 30);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d status words never arrived", results_due.size());
            errors++;
        end
        $display("Summary: %0d commands, %0d serial frames, %0d bytes returned, %0d overflows",
                 cmds_taken, frames_queued, bytes_returned, ovf_reports);
        $display("Summary: both polarities, receiver off, minimum to full-scale timing, %0d stalls",
                 long_holds);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
